// ===== src/pqs_pkg.sv =====
package pqs_pkg;

	localparam int SLOTS   = 8;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int TIME_W  = 20;
	localparam int ID_W    = 8;
	localparam int PRIO_W  = 8;
	localparam int ARR_W   = 16;
	localparam int BURST_W = 16;
	localparam int QUANT_W = 8;
	localparam int STAT_W  = 3;

	localparam logic [TIME_W-1:0]  TIME_MAX    = '1;
	localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(2);

	typedef logic [STAT_W-1:0] status_t;
	localparam status_t STAT_SLICE     = 3'd0;
	localparam status_t STAT_LOADED    = 3'd1;
	localparam status_t STAT_FULL      = 3'd2;
	localparam status_t STAT_BAD_BURST = 3'd3;
	localparam status_t STAT_EMPTY     = 3'd4;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [PRIO_W-1:0]  prio;
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
		logic [BURST_W-1:0] remaining;
	} entry_t;

	typedef struct packed {
		logic              wr_en;
		logic              set_valid;
		logic              clr_valid;
		logic [SLOT_W-1:0] wr_addr;
		logic [SLOT_W-1:0] rd_addr;
	} tbl_ctrl_t;

endpackage

// ===== src/pqs_alu.sv =====
module pqs_alu (
	input  pqs_pkg::alu_op_t            op,
	input  logic [pqs_pkg::TIME_W-1:0]  a,
	input  logic [pqs_pkg::TIME_W-1:0]  b,
	output logic [pqs_pkg::TIME_W-1:0]  res,
	output logic                        carry
);
	import pqs_pkg::*;

	logic [TIME_W:0] sum;

	// carry is the carry out on add and the borrow on subtract
	always_comb begin
		if (op == ALU_ADD) begin
			sum = {1'b0, a} + {1'b0, b};
		end else begin
			sum = {1'b0, a} - {1'b0, b};
		end
	end

	assign res   = sum[TIME_W-1:0];
	assign carry = sum[TIME_W];

endmodule

// ===== src/pqs_table.sv =====
module pqs_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pqs_pkg::tbl_ctrl_t         ctrl,
	input  pqs_pkg::entry_t            wr_entry,
	output pqs_pkg::entry_t            rd_data,
	output logic [pqs_pkg::SLOTS-1:0]  valid
);
	import pqs_pkg::*;

	entry_t            mem_q [SLOTS];
	entry_t            rd_q;
	logic [SLOTS-1:0]  valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[ctrl.wr_addr] <= wr_entry;
		end
		rd_q <= mem_q[ctrl.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ctrl.set_valid) begin
				valid_q[ctrl.wr_addr] <= 1'b1;
			end
			if (ctrl.clr_valid) begin
				valid_q[ctrl.wr_addr] <= 1'b0;
			end
		end
	end

	assign rd_data = rd_q;
	assign valid   = valid_q;

endmodule

// ===== src/preemptive_priority_quantum_scheduler_top.sv =====
// Preemptive priority scheduler with a time quantum over an 8-slot task table. A load item
// (mode 0) stores a task in the lowest free slot. A dispatch item (mode 1) runs one slice:
// the slot table has one read port, so the sequencer sweeps it twice, once for the earliest
// arrival and once for the highest ready priority, one slot per cycle, and then runs the
// slice and completion steps, and the turnaround and waiting steps when the task finishes,
// one at a time through a single shared 20-bit add/subtract unit. A dispatch on an empty
// table skips the sweeps and goes straight to the output state. One item is in work at a
// time; in_ready is high only while the sequencer is idle, and a finished result waits in
// the output register without holding up the next item until that item's own result is
// ready. The quantum register may be written whenever the block is idle; a quantum of zero
// runs as one.
module preemptive_priority_quantum_scheduler_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [pqs_pkg::ID_W-1:0]      task_id,
	input  logic [pqs_pkg::PRIO_W-1:0]    task_priority,
	input  logic [pqs_pkg::ARR_W-1:0]     arrival_time,
	input  logic [pqs_pkg::BURST_W-1:0]   burst_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pqs_pkg::STAT_W-1:0]    status,
	output logic [pqs_pkg::ID_W-1:0]      ran_id,
	output logic [pqs_pkg::TIME_W-1:0]    slice_start,
	output logic [pqs_pkg::QUANT_W-1:0]   slice_length,
	output logic                          finished,
	output logic [pqs_pkg::TIME_W-1:0]    completion_time,
	output logic [pqs_pkg::TIME_W-1:0]    turnaround,
	output logic [pqs_pkg::TIME_W-1:0]    waiting,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pqs_pkg::QUANT_W-1:0]   cfg_data
);
	import pqs_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_LOAD  = 11'b00000000010,
		S_SCANA = 11'b00000000100,
		S_ADV   = 11'b00000001000,
		S_SCANP = 11'b00000010000,
		S_FETCH = 11'b00000100000,
		S_RUN   = 11'b00001000000,
		S_END   = 11'b00010000000,
		S_TAT   = 11'b00100000000,
		S_WT    = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t              state_q;
	logic [QUANT_W-1:0]  quantum_q;
	logic [TIME_W-1:0]   now_q;
	entry_t              ld_q;
	logic [CNT_W-1:0]    idx_q;
	logic                rd_en_s1;
	logic [SLOT_W-1:0]   rd_slot_s1;
	logic                any_q;
	logic [ARR_W-1:0]    earliest_q;
	logic                found_q;
	logic [PRIO_W-1:0]   best_q;
	logic [SLOT_W-1:0]   pick_q;
	entry_t              entry_q;
	logic [QUANT_W-1:0]  run_q;
	logic [BURST_W-1:0]  rem_q;
	logic [TIME_W-1:0]   start_q;
	logic [TIME_W-1:0]   done_q;
	logic [TIME_W-1:0]   tat_q;
	logic [TIME_W-1:0]   wt_q;
	logic                fin_q;
	status_t             status_q;

	logic                out_valid_q;
	status_t             status_out_q;
	logic [ID_W-1:0]     ran_id_q;
	logic [TIME_W-1:0]   slice_start_q;
	logic [QUANT_W-1:0]  slice_length_q;
	logic                finished_q;
	logic [TIME_W-1:0]   completion_q;
	logic [TIME_W-1:0]   turnaround_q;
	logic [TIME_W-1:0]   waiting_q;

	tbl_ctrl_t           tbl_ctrl;
	entry_t              wr_entry;
	entry_t              rd_data;
	logic [SLOTS-1:0]    valid;

	alu_op_t             alu_op;
	logic [TIME_W-1:0]   alu_a;
	logic [TIME_W-1:0]   alu_b;
	logic [TIME_W-1:0]   alu_res;
	logic                alu_carry;

	logic                free_any;
	logic [SLOT_W-1:0]   free_slot;
	logic [QUANT_W-1:0]  q_eff;
	logic                scan_more;
	logic                rd_hit;
	logic                out_free;
	logic                load_ok;

	pqs_alu u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.res   (alu_res),
		.carry (alu_carry)
	);

	pqs_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (tbl_ctrl),
		.wr_entry (wr_entry),
		.rd_data  (rd_data),
		.valid    (valid)
	);

	// lowest free slot
	always_comb begin
		free_any  = 1'b0;
		free_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid[i]) begin
				free_any  = 1'b1;
				free_slot = SLOT_W'(i);
			end
		end
	end

	assign q_eff     = (quantum_q == '0) ? QUANT_W'(1) : quantum_q;
	assign scan_more = idx_q < CNT_W'(SLOTS);
	assign rd_hit    = rd_en_s1 && valid[rd_slot_s1];
	assign out_free  = !out_valid_q || out_ready;
	assign load_ok   = (ld_q.burst != '0) && free_any;
	assign in_ready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;

	// operand selection for the shared unit
	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_SCANA: begin
				alu_a = TIME_W'(rd_data.arrival);
				alu_b = TIME_W'(earliest_q);
			end
			S_ADV: begin
				alu_a = now_q;
				alu_b = TIME_W'(earliest_q);
			end
			S_SCANP: begin
				alu_a = now_q;
				alu_b = TIME_W'(rd_data.arrival);
			end
			S_RUN: begin
				alu_a = TIME_W'(rd_data.remaining);
				alu_b = TIME_W'(q_eff);
			end
			S_END: begin
				alu_op = ALU_ADD;
				alu_a  = now_q;
				alu_b  = TIME_W'(run_q);
			end
			S_TAT: begin
				alu_a = done_q;
				alu_b = TIME_W'(entry_q.arrival);
			end
			S_WT: begin
				alu_a = tat_q;
				alu_b = TIME_W'(entry_q.burst);
			end
			default: begin
				alu_op = ALU_SUB;
			end
		endcase
	end

	// table access
	always_comb begin
		tbl_ctrl         = '0;
		tbl_ctrl.rd_addr = idx_q[SLOT_W-1:0];
		wr_entry         = ld_q;
		case (state_q)
			S_LOAD: begin
				tbl_ctrl.wr_en     = load_ok;
				tbl_ctrl.set_valid = load_ok;
				tbl_ctrl.wr_addr   = free_slot;
			end
			S_FETCH: begin
				tbl_ctrl.rd_addr = pick_q;
			end
			S_END: begin
				tbl_ctrl.wr_en     = 1'b1;
				tbl_ctrl.clr_valid = rem_q == '0;
				tbl_ctrl.wr_addr   = pick_q;
				wr_entry           = entry_q;
				wr_entry.remaining = rem_q;
			end
			default: begin
				tbl_ctrl.wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			quantum_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			now_q      <= '0;
			idx_q      <= '0;
			rd_en_s1   <= 1'b0;
			rd_slot_s1 <= '0;
			any_q      <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			rd_en_s1   <= ((state_q == S_SCANA) || (state_q == S_SCANP)) && scan_more;
			rd_slot_s1 <= idx_q[SLOT_W-1:0];
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q <= '0;
						any_q <= 1'b0;
						if (!mode) begin
							state_q <= S_LOAD;
						end else if (valid == '0) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_SCANA;
						end
					end
				end
				S_LOAD: begin
					state_q <= S_OUT;
				end
				S_SCANA: begin
					if (rd_hit && (!any_q || alu_carry)) begin
						any_q <= 1'b1;
					end
					if (scan_more) begin
						idx_q <= idx_q + CNT_W'(1);
					end else if (!rd_en_s1) begin
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					if (alu_carry) begin
						now_q <= TIME_W'(earliest_q);
					end
					idx_q   <= '0;
					found_q <= 1'b0;
					state_q <= S_SCANP;
				end
				S_SCANP: begin
					if (rd_hit && !alu_carry && (!found_q || rd_data.prio > best_q)) begin
						found_q <= 1'b1;
					end
					if (scan_more) begin
						idx_q <= idx_q + CNT_W'(1);
					end else if (!rd_en_s1) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_RUN;
				end
				S_RUN: begin
					state_q <= S_END;
				end
				S_END: begin
					// completion time saturates at the top of the time range
					now_q   <= alu_carry ? TIME_MAX : alu_res;
					state_q <= (rem_q == '0) ? S_TAT : S_OUT;
				end
				S_TAT: begin
					state_q <= S_WT;
				end
				S_WT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload and per-dispatch working values
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ld_q.id        <= task_id;
				ld_q.prio      <= task_priority;
				ld_q.arrival   <= arrival_time;
				ld_q.burst     <= burst_length;
				ld_q.remaining <= burst_length;
				entry_q        <= '0;
				run_q          <= '0;
				start_q        <= '0;
				done_q         <= '0;
				tat_q          <= '0;
				wt_q           <= '0;
				fin_q          <= 1'b0;
				status_q       <= STAT_EMPTY;
			end
			S_LOAD: begin
				if (ld_q.burst == '0) begin
					status_q <= STAT_BAD_BURST;
				end else if (!free_any) begin
					status_q <= STAT_FULL;
				end else begin
					status_q <= STAT_LOADED;
				end
			end
			S_SCANA: begin
				if (rd_hit && (!any_q || alu_carry)) begin
					earliest_q <= rd_data.arrival;
				end
			end
			S_SCANP: begin
				if (rd_hit && !alu_carry && (!found_q || rd_data.prio > best_q)) begin
					best_q <= rd_data.prio;
					pick_q <= rd_slot_s1;
				end
			end
			S_RUN: begin
				// borrow means the remaining work is shorter than the quantum
				entry_q <= rd_data;
				run_q   <= alu_carry ? rd_data.remaining[QUANT_W-1:0] : q_eff;
				rem_q   <= alu_carry ? '0 : alu_res[BURST_W-1:0];
			end
			S_END: begin
				start_q  <= now_q;
				done_q   <= alu_carry ? TIME_MAX : alu_res;
				fin_q    <= rem_q == '0;
				status_q <= STAT_SLICE;
			end
			S_TAT: begin
				tat_q <= alu_res;
			end
			S_WT: begin
				wt_q <= alu_carry ? '0 : alu_res;
			end
			default: begin
				fin_q <= fin_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			status_out_q   <= status_q;
			ran_id_q       <= entry_q.id;
			slice_start_q  <= start_q;
			slice_length_q <= run_q;
			finished_q     <= fin_q;
			completion_q   <= done_q;
			turnaround_q   <= tat_q;
			waiting_q      <= wt_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_out_q;
	assign ran_id          = ran_id_q;
	assign slice_start     = slice_start_q;
	assign slice_length    = slice_length_q;
	assign finished        = finished_q;
	assign completion_time = completion_q;
	assign turnaround      = turnaround_q;
	assign waiting         = waiting_q;

endmodule

// ===== src/pqs_checker.sv =====
module pqs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          mode,
	input logic [pqs_pkg::ID_W-1:0]      task_id,
	input logic [pqs_pkg::PRIO_W-1:0]    task_priority,
	input logic [pqs_pkg::ARR_W-1:0]     arrival_time,
	input logic [pqs_pkg::BURST_W-1:0]   burst_length,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [pqs_pkg::STAT_W-1:0]    status,
	input logic [pqs_pkg::ID_W-1:0]      ran_id,
	input logic [pqs_pkg::TIME_W-1:0]    slice_start,
	input logic [pqs_pkg::QUANT_W-1:0]   slice_length,
	input logic                          finished,
	input logic [pqs_pkg::TIME_W-1:0]    completion_time,
	input logic [pqs_pkg::TIME_W-1:0]    turnaround,
	input logic [pqs_pkg::TIME_W-1:0]    waiting,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [pqs_pkg::QUANT_W-1:0]   cfg_data
);
	import pqs_pkg::*;

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again straight after an item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(ran_id)
			&& $stable(completion_time))
		else $error("stalled result changed");

	a_non_slice_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_SLICE |-> ran_id == '0 && slice_length == '0
			&& !finished && completion_time == '0 && turnaround == '0)
		else $error("non-slice result carries slice fields");

	a_slice_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_SLICE |-> slice_length != '0
			&& completion_time >= slice_start && waiting <= turnaround)
		else $error("slice timing inconsistent");

	a_unfinished_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !finished |-> turnaround == '0 && waiting == '0)
		else $error("turnaround or waiting set on unfinished slice");

endmodule

bind preemptive_priority_quantum_scheduler_top pqs_checker u_pqs_checker (.*);
